### rtl/c3f_pkg.sv
// ----------------------------------------------------------------------------
// c3f_pkg
// Shared types, constants and the luma function of the 3x3 cross filter.
// ----------------------------------------------------------------------------
package c3f_pkg;

  // pixel and channel geometry
  localparam int CH_BITS   = 8;
  localparam int NUM_CH    = 3;
  localparam int PIX_BITS  = NUM_CH * CH_BITS;
  localparam int MAX_WIDTH = 2048;
  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int WID_BITS  = COL_BITS + 1;
  localparam int ROW_BITS  = 13;
  // row counter runs to height+1 while the last row drains
  localparam int ROWC_BITS = ROW_BITS + 1;
  localparam int CNT_BITS  = 25;
  localparam int OIDX_BITS = 24;
  localparam int LAP_BITS  = CH_BITS + 3;

  // configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 13;
  localparam logic [CH_BITS-1:0] THRESH_RESET = 8'd128;

  // rounded Q16 luma weights
  localparam int LUMA_SUM_BITS = CH_BITS + 16;
  localparam logic [15:0] LUMA_R   = 16'd19595;
  localparam logic [15:0] LUMA_G   = 16'd38470;
  localparam logic [15:0] LUMA_B   = 16'd7471;
  localparam logic [15:0] LUMA_RND = 16'd32768;

  typedef logic [PIX_BITS-1:0]        pix_t;
  typedef logic [CH_BITS-1:0]         luma_t;
  typedef logic signed [LAP_BITS-1:0] lap_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic {
    MODE_SHARPEN = 1'b0,
    MODE_EDGE    = 1'b1
  } mode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_THRESH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    op_t  op;
    pix_t pixel_rgb;
  } in_item_t;

  typedef struct packed {
    pix_t out_rgb;
    logic frame_end;
  } out_item_t;

  // frame geometry derived from the width and height registers
  typedef struct packed {
    logic [COL_BITS-1:0]  wm1;
    logic [WID_BITS-1:0]  wp1;
    logic [ROW_BITS-1:0]  h;
    logic [OIDX_BITS-1:0] tm1;
  } geom_t;

  // per-stage control
  typedef struct packed {
    logic valid;
    logic frame_end;
  } stage_ctl_t;

  // center and cross neighbors after border replication
  typedef struct packed {
    pix_t cen;
    pix_t up;
    pix_t dn;
    pix_t lf;
    pix_t rt;
  } nbr_t;

  typedef struct packed {
    luma_t cen;
    luma_t up;
    luma_t dn;
    luma_t lf;
    luma_t rt;
  } gnbr_t;

  // gray = (19595 R + 38470 G + 7471 B + 32768) >> 16
  function automatic luma_t luma(input pix_t p);
    logic [LUMA_SUM_BITS-1:0] s;
    s = LUMA_SUM_BITS'(p[2*CH_BITS +: CH_BITS]) * LUMA_SUM_BITS'(LUMA_R)
      + LUMA_SUM_BITS'(p[CH_BITS +: CH_BITS]) * LUMA_SUM_BITS'(LUMA_G)
      + LUMA_SUM_BITS'(p[0 +: CH_BITS]) * LUMA_SUM_BITS'(LUMA_B)
      + LUMA_SUM_BITS'(LUMA_RND);
    return s[LUMA_SUM_BITS-1 -: CH_BITS];
  endfunction

endpackage

### rtl/c3f_line_buf.sv
// ----------------------------------------------------------------------------
// c3f_line_buf
// Two line stores, one row each, with registered read and write bypass.
// ----------------------------------------------------------------------------
module c3f_line_buf import c3f_pkg::*; (
  input  logic                clk,
  input  logic                we,
  input  logic [COL_BITS-1:0] waddr,
  input  pix_t                wdata_a,
  input  pix_t                wdata_b,
  input  logic [COL_BITS-1:0] raddr,
  output pix_t                rdata_a,
  output pix_t                rdata_b
);

  pix_t mem_a [MAX_WIDTH];
  pix_t mem_b [MAX_WIDTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_a[waddr] <= wdata_a;
      mem_b[waddr] <= wdata_b;
    end
  end

  // read port, forwards a same-cycle write to the same column
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_a <= wdata_a;
      rdata_b <= wdata_b;
    end else begin
      rdata_a <= mem_a[raddr];
      rdata_b <= mem_b[raddr];
    end
  end

endmodule

### rtl/c3f_front.sv
// ----------------------------------------------------------------------------
// c3f_front
// Raster counters, line stores and window; forms the cross neighborhood of
// the pixel that leaves on each request, with border replication.
// ----------------------------------------------------------------------------
module c3f_front import c3f_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  geom_t      geo,
  input  logic       geo_clr,
  input  logic       in_valid,
  input  in_item_t   in_data,
  input  logic       load,
  output stage_ctl_t a_ctl,
  output nbr_t       a_nbr
);

  logic [COL_BITS-1:0]  col, col_next;
  logic [ROWC_BITS-1:0] row, row_next;
  logic [CNT_BITS-1:0]  pix_cnt, pix_cnt_next;
  logic [OIDX_BITS-1:0] out_idx, out_idx_next;

  // window: newest column of each row plus the previous middle pixel
  pix_t win_top, win_mid, win_mid_prev, win_bot;
  pix_t rd_a, rd_b, px;
  nbr_t nbr;

  logic accept, complete, advance, emit, have, last_out;
  logic col_z, last_col, top_row, bot_row, left_col;

  // request decode
  assign accept   = in_valid && load;
  assign complete = pix_cnt > CNT_BITS'(geo.tm1);
  assign advance  = accept && !((in_data.op == OP_FLUSH) && !complete);
  assign emit     = (out_idx <= geo.tm1) && (pix_cnt >= CNT_BITS'(geo.wp1));
  assign have     = advance && emit;
  assign last_out = out_idx == geo.tm1;
  assign px       = complete ? '0 : in_data.pixel_rgb;

  // position of the emitted pixel relative to the frame border
  assign col_z    = col == '0;
  assign last_col = col == geo.wm1;
  assign top_row  = col_z ? (row == ROWC_BITS'(2)) : (row == ROWC_BITS'(1));
  assign bot_row  = col_z ? (row > ROWC_BITS'(geo.h)) : (row >= ROWC_BITS'(geo.h));
  assign left_col = col_z ? (geo.wm1 == '0) : (col == COL_BITS'(1));

  // neighbors with replication at the borders
  always_comb begin
    nbr.cen = win_mid;
    nbr.up  = top_row  ? win_mid : win_top;
    nbr.dn  = bot_row  ? win_mid : win_bot;
    nbr.lf  = left_col ? win_mid : win_mid_prev;
    nbr.rt  = col_z    ? win_mid : rd_b;
  end

  // counter next values
  always_comb begin
    col_next     = col;
    row_next     = row;
    pix_cnt_next = pix_cnt;
    out_idx_next = out_idx;
    priority if (geo_clr) begin
      col_next     = '0;
      row_next     = '0;
      pix_cnt_next = '0;
      out_idx_next = '0;
    end else if (advance && have && last_out) begin
      col_next     = '0;
      row_next     = '0;
      pix_cnt_next = '0;
      out_idx_next = '0;
    end else if (advance) begin
      col_next     = last_col ? '0 : col + 1'b1;
      row_next     = last_col ? row + 1'b1 : row;
      pix_cnt_next = pix_cnt + 1'b1;
      out_idx_next = out_idx + OIDX_BITS'(have);
    end else begin
      col_next = col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      pix_cnt <= '0;
      out_idx <= '0;
    end else begin
      col     <= col_next;
      row     <= row_next;
      pix_cnt <= pix_cnt_next;
      out_idx <= out_idx_next;
    end
  end

  // line stores, read one column ahead
  c3f_line_buf u_line_buf (
    .clk     (clk),
    .we      (advance),
    .waddr   (col),
    .wdata_a (rd_b),
    .wdata_b (px),
    .raddr   (col_next),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // window shift
  always_ff @(posedge clk) begin
    if (advance) begin
      win_top      <= rd_a;
      win_mid_prev <= win_mid;
      win_mid      <= rd_b;
      win_bot      <= px;
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl.valid     <= 1'b0;
      a_ctl.frame_end <= 1'b0;
    end else if (load) begin
      a_ctl.valid     <= have;
      a_ctl.frame_end <= last_out;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_nbr <= nbr;
    end
  end

  // column never passes the last column of the row
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col <= geo.wm1)
    else $error("column counter beyond row width");

  // last pixel of the frame restarts all counters
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    have && last_out && !geo_clr |=> (col == '0) && (row == '0) &&
      (pix_cnt == '0) && (out_idx == '0))
    else $error("counters not cleared at frame end");

  // flush before the frame is in changes nothing
  a_early_flush: assert property (@(posedge clk) disable iff (rst)
    accept && (in_data.op == OP_FLUSH) && !complete && !geo_clr |=>
      $stable(pix_cnt) && $stable(out_idx) && !a_ctl.valid)
    else $error("early flush changed state");

  // outputs never run ahead of inputs
  a_out_behind: assert property (@(posedge clk) disable iff (rst)
    CNT_BITS'(out_idx) <= pix_cnt)
    else $error("output index ahead of pixel count");

endmodule

### rtl/c3f_lane.sv
// ----------------------------------------------------------------------------
// c3f_lane
// One channel of the cross kernel: 4*center minus the four neighbors.
// ----------------------------------------------------------------------------
module c3f_lane import c3f_pkg::*; (
  input  logic               clk,
  input  logic               load,
  input  logic [CH_BITS-1:0] cen,
  input  logic [CH_BITS-1:0] up,
  input  logic [CH_BITS-1:0] dn,
  input  logic [CH_BITS-1:0] lf,
  input  logic [CH_BITS-1:0] rt,
  output lap_t               lap
);

  localparam int PAD = LAP_BITS - CH_BITS;

  logic [LAP_BITS-1:0] lap_raw;

  // two's complement sum, range fits the lane width
  always_comb begin
    lap_raw = ({{PAD{1'b0}}, cen} << 2)
            - {{PAD{1'b0}}, up} - {{PAD{1'b0}}, dn}
            - {{PAD{1'b0}}, lf} - {{PAD{1'b0}}, rt};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lap <= lap_t'(lap_raw);
    end
  end

endmodule

### rtl/c3f_merge.sv
// ----------------------------------------------------------------------------
// c3f_merge
// Combines the lane results: saturated sharpen per channel or the edge
// threshold on the gray lane; holds the output register.
// ----------------------------------------------------------------------------
module c3f_merge import c3f_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  stage_ctl_t         c_ctl,
  input  pix_t               c_cen,
  input  lap_t               lap_ch [NUM_CH],
  input  lap_t               lap_gray,
  input  mode_t              mode,
  input  logic [CH_BITS-1:0] thresh,
  input  logic               out_stall,
  output logic               out_valid,
  output out_item_t          out_data,
  output logic               free
);

  localparam int PAD = LAP_BITS + 1 - CH_BITS;

  logic [LAP_BITS:0] sum;
  pix_t              sharp;
  logic              white;
  pix_t              rgb;

  assign free = !out_valid || !out_stall;

  // sharpen: lap + center, clamped to the channel range
  always_comb begin
    sum   = '0;
    sharp = '0;
    for (int k = 0; k < NUM_CH; k++) begin
      sum = {lap_ch[k][LAP_BITS-1], lap_ch[k]} + {{PAD{1'b0}}, c_cen[k*CH_BITS +: CH_BITS]};
      if (sum[LAP_BITS]) begin
        sharp[k*CH_BITS +: CH_BITS] = '0;
      end else if (|sum[LAP_BITS-1:CH_BITS]) begin
        sharp[k*CH_BITS +: CH_BITS] = '1;
      end else begin
        sharp[k*CH_BITS +: CH_BITS] = sum[CH_BITS-1:0];
      end
    end
  end

  // edge: nonnegative response at or above the threshold
  assign white = !lap_gray[LAP_BITS-1] &&
                 (lap_gray[LAP_BITS-2:0] >= (LAP_BITS-1)'(thresh));

  always_comb begin
    unique case (mode)
      MODE_EDGE:    rgb = white ? '1 : '0;
      MODE_SHARPEN: rgb = sharp;
      default:      rgb = sharp;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= c_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free) begin
      out_data.out_rgb   <= rgb;
      out_data.frame_end <= c_ctl.frame_end;
    end
  end

endmodule

### rtl/conv3x3_sharpen_edge_filter_unit.sv
// ----------------------------------------------------------------------------
// conv3x3_sharpen_edge_filter_unit
// 3x3 cross-kernel sharpen / edge filter over a raster RGB888 stream.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                 payload
//   in        sink       in_valid / in_stall       in_item_t  (op, pixel_rgb)
//   out       source     out_valid / out_stall     out_item_t (out_rgb, frame_end)
//   cfg       sink       cfg_we                    cfg_index, cfg_data
//
// One request per clock while in_stall is low; the line stores read one column ahead
// and write the current column on a separate port, once per advancing request.
// out_valid rises through stages a, b, c and the output register once the request
// that completes a window is accepted; it comes image_width+1 requests after the pixel.
// Synchronous reset clears counters, pipeline valids and registers; the line
// stores are not cleared.
// A waiting result holds the output register; up to three more results queue
// in the pipeline stages before in_stall rises. Requests that yield no result
// pass as bubbles and do not fill the pipeline.
//
module conv3x3_sharpen_edge_filter_unit import c3f_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  // configuration registers
  mode_t                mode;
  logic [CH_BITS-1:0]   thresh;
  logic [WID_BITS-1:0]  width_eff, width_new, width_sel;
  logic [ROW_BITS-1:0]  height_eff, height_new, height_sel;
  logic [OIDX_BITS-1:0] tm1;
  logic [WID_BITS+ROW_BITS-1:0] area;
  cfg_reg_t             cfg_reg;
  logic                 geo_clr;
  geom_t                geo;

  // pipeline
  stage_ctl_t a_ctl, b_ctl, c_ctl;
  nbr_t       a_nbr, b_nbr;
  gnbr_t      b_gray;
  pix_t       c_cen;
  lap_t       lap_ch [NUM_CH];
  lap_t       lap_gray;
  logic       a_load, b_load, c_load, free;

  assign cfg_reg = cfg_reg_t'(cfg_index);
  assign geo_clr = cfg_we && ((cfg_reg == REG_WIDTH) || (cfg_reg == REG_HEIGHT));

  // effective geometry of the value being written
  always_comb begin
    if (cfg_data[WID_BITS-1:0] == '0) begin
      width_new = WID_BITS'(1);
    end else if (cfg_data[WID_BITS-1:0] > WID_BITS'(MAX_WIDTH)) begin
      width_new = WID_BITS'(MAX_WIDTH);
    end else begin
      width_new = cfg_data[WID_BITS-1:0];
    end
    height_new = (cfg_data[ROW_BITS-1:0] == '0) ? ROW_BITS'(1) : cfg_data[ROW_BITS-1:0];
    width_sel  = (cfg_reg == REG_WIDTH)  ? width_new  : width_eff;
    height_sel = (cfg_reg == REG_HEIGHT) ? height_new : height_eff;
    area       = (WID_BITS+ROW_BITS)'(width_sel) * (WID_BITS+ROW_BITS)'(height_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_SHARPEN;
      thresh     <= THRESH_RESET;
      width_eff  <= WID_BITS'(1);
      height_eff <= ROW_BITS'(1);
      tm1        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg)
        REG_MODE: begin
          mode <= mode_t'(cfg_data[0]);
        end
        REG_WIDTH: begin
          width_eff <= width_new;
          tm1       <= OIDX_BITS'(area - 1'b1);
        end
        REG_HEIGHT: begin
          height_eff <= height_new;
          tm1        <= OIDX_BITS'(area - 1'b1);
        end
        REG_THRESH: begin
          thresh <= cfg_data[CH_BITS-1:0];
        end
        default: begin
          mode <= mode;
        end
      endcase
    end
  end

  always_comb begin
    geo.wm1 = COL_BITS'(width_eff - 1'b1);
    geo.wp1 = width_eff + 1'b1;
    geo.h   = height_eff;
    geo.tm1 = tm1;
  end

  // stage loads: a stage takes new data when empty or when drained
  assign c_load   = !c_ctl.valid || free;
  assign b_load   = !b_ctl.valid || c_load;
  assign a_load   = !a_ctl.valid || b_load;
  assign in_stall = !a_load;

  // window front end
  c3f_front u_front (
    .clk      (clk),
    .rst      (rst),
    .geo      (geo),
    .geo_clr  (geo_clr),
    .in_valid (in_valid),
    .in_data  (in_data),
    .load     (a_load),
    .a_ctl    (a_ctl),
    .a_nbr    (a_nbr)
  );

  // gray conversion of the five neighborhood pixels
  always_ff @(posedge clk) begin
    if (rst) begin
      b_ctl <= '0;
    end else if (b_load) begin
      b_ctl <= a_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_nbr      <= a_nbr;
      b_gray.cen <= luma(a_nbr.cen);
      b_gray.up  <= luma(a_nbr.up);
      b_gray.dn  <= luma(a_nbr.dn);
      b_gray.lf  <= luma(a_nbr.lf);
      b_gray.rt  <= luma(a_nbr.rt);
    end
  end

  // kernel lanes: one per color channel plus one on gray
  for (genvar k = 0; k < NUM_CH; k++) begin : g_ch_lane
    c3f_lane u_lane (
      .clk  (clk),
      .load (c_load),
      .cen  (b_nbr.cen[k*CH_BITS +: CH_BITS]),
      .up   (b_nbr.up[k*CH_BITS +: CH_BITS]),
      .dn   (b_nbr.dn[k*CH_BITS +: CH_BITS]),
      .lf   (b_nbr.lf[k*CH_BITS +: CH_BITS]),
      .rt   (b_nbr.rt[k*CH_BITS +: CH_BITS]),
      .lap  (lap_ch[k])
    );
  end

  c3f_lane u_gray_lane (
    .clk  (clk),
    .load (c_load),
    .cen  (b_gray.cen),
    .up   (b_gray.up),
    .dn   (b_gray.dn),
    .lf   (b_gray.lf),
    .rt   (b_gray.rt),
    .lap  (lap_gray)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctl <= '0;
    end else if (c_load) begin
      c_ctl <= b_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (c_load) begin
      c_cen <= b_nbr.cen;
    end
  end

  // merge and output register
  c3f_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .c_ctl     (c_ctl),
    .c_cen     (c_cen),
    .lap_ch    (lap_ch),
    .lap_gray  (lap_gray),
    .mode      (mode),
    .thresh    (thresh),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .free      (free)
  );

endmodule

### bench/tb_conv3x3_sharpen_edge_filter_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_conv3x3_sharpen_edge_filter_unit
// Self-checking bench for the 3x3 cross sharpen / edge filter. Whole frames
// are streamed through the request channel while a scoreboard process
// replays each accepted request on its own line-store and window model.
// Every result is compared field by field with the oldest predicted pixel.
// Random gaps and stalls sit on both channels. Geometry, mode and threshold
// are rewritten between frames, and frames may be aborted part way.
// ----------------------------------------------------------------------------
module tb_conv3x3_sharpen_edge_filter_unit;
  import c3f_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEM_BUDGET   = 1900;
  localparam int WIDE_COLS     = 256;

  typedef enum int {
    PAT_RANDOM,
    PAT_CHECKER,
    PAT_WHITE,
    PAT_BLACK
  } pattern_t;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  in_item_t                 in_data   = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_item_t                out_data;
  logic                     cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

  // filter model state
  pix_t        prev_row [MAX_WIDTH] = '{default: '0};
  pix_t        last_row [MAX_WIDTH] = '{default: '0};
  pix_t        win [9]              = '{default: '0};
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  int unsigned out_pos = 0;
  mode_t       cur_mode   = MODE_SHARPEN;
  logic [11:0] width_reg  = 12'd1;
  logic [12:0] height_reg = 13'd1;
  logic [7:0]  thresh_reg = THRESH_RESET;

  out_item_t   want_pixels [$];
  int          n_errors  = 0;
  int          n_checked = 0;
  int          n_frames  = 0;
  int unsigned n_items   = 0;

  // traffic shaping shared between the sender and the receiver
  bit          no_gaps      = 1'b0;
  bit          hold_pending = 1'b0;
  int          stall_left   = 0;

  conv3x3_sharpen_edge_filter_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // rounded Q16 luma
  function automatic int gray_of(input pix_t p);
    return (int'(p[2*CH_BITS +: CH_BITS]) * int'(LUMA_R)
          + int'(p[CH_BITS +: CH_BITS]) * int'(LUMA_G)
          + int'(p[0 +: CH_BITS]) * int'(LUMA_B) + int'(LUMA_RND)) >>> 16;
  endfunction

  // cross kernel on an already border-replicated neighborhood
  function automatic pix_t cross_filter(input pix_t c, input pix_t u, input pix_t d,
                                        input pix_t l, input pix_t r);
    int   v;
    int   k;
    pix_t res;
    if (cur_mode == MODE_EDGE) begin
      v = 4 * gray_of(c) - gray_of(u) - gray_of(d) - gray_of(l) - gray_of(r);
      if (v >= int'(thresh_reg)) return {PIX_BITS{1'b1}};
      return '0;
    end
    res = '0;
    for (k = 0; k < NUM_CH; k++) begin
      v = 5 * int'(c[k*CH_BITS +: CH_BITS]) - int'(u[k*CH_BITS +: CH_BITS])
        - int'(d[k*CH_BITS +: CH_BITS]) - int'(l[k*CH_BITS +: CH_BITS])
        - int'(r[k*CH_BITS +: CH_BITS]);
      if (v < 0) v = 0;
      if (v > (1 << CH_BITS) - 1) v = (1 << CH_BITS) - 1;
      res[k*CH_BITS +: CH_BITS] = v[CH_BITS-1:0];
    end
    return res;
  endfunction

  // advance the model by one accepted request, queue the pixel it yields
  task automatic filter_step(input in_item_t req);
    int unsigned w, h, total, j, rr, n, r, c;
    int          k;
    bit          complete, emit, have;
    pix_t        px, cen, up, dn, lf, rt, oa, ob;
    out_item_t   res;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg == 0) ? 1 : height_reg;
    total = w * h;
    px = req.pixel_rgb;
    have = 1'b0;
    r = 0;
    c = 0;
    cen = '0; up = '0; dn = '0; lf = '0; rt = '0;
    if (col_pos >= w) col_pos = 0;
    j = col_pos;
    rr = row_pos;
    n = rr * w + j;
    complete = (n >= total);
    // flush while the frame is still arriving does nothing
    if (req.op == OP_FLUSH && !complete) return;
    if (complete) px = '0;
    emit = (out_pos < total) && (n >= w + 1);
    // column zero closes the row before last
    if (emit && j == 0) begin
      r = rr - 2;
      c = w - 1;
      cen = win[5]; up = win[2]; dn = win[8]; lf = win[4]; rt = cen;
      have = 1'b1;
    end
    oa = prev_row[j];
    ob = last_row[j];
    prev_row[j] = ob;
    last_row[j] = px;
    for (k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = oa;
    win[5] = ob;
    win[8] = px;
    if (emit && j != 0) begin
      r = rr - 1;
      c = j - 1;
      cen = win[4]; up = win[1]; dn = win[7]; lf = win[3]; rt = win[5];
      have = 1'b1;
    end
    col_pos = j + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = rr + 1;
    end
    if (!have) return;
    // border replication
    if (r == 0) up = cen;
    if (r >= h - 1) dn = cen;
    if (c == 0) lf = cen;
    if (c >= w - 1) rt = cen;
    res.out_rgb   = cross_filter(cen, up, dn, lf, rt);
    res.frame_end = (out_pos == total - 1);
    out_pos++;
    if (res.frame_end) begin
      col_pos = 0;
      row_pos = 0;
      out_pos = 0;
    end
    want_pixels.push_back(res);
  endtask

  // register writes, request prediction and result checking
  always @(posedge clk) begin : scoreboard
    out_item_t want;
    if (!rst) begin
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          REG_MODE:   cur_mode = mode_t'(cfg_data[0]);
          REG_WIDTH: begin
            width_reg = cfg_data[11:0];
            col_pos = 0; row_pos = 0; out_pos = 0;
          end
          REG_HEIGHT: begin
            height_reg = cfg_data[12:0];
            col_pos = 0; row_pos = 0; out_pos = 0;
          end
          REG_THRESH: thresh_reg = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) filter_step(in_data);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (want_pixels.size() == 0) begin
          $error("unexpected result: out_rgb %h frame_end %b",
                 out_data.out_rgb, out_data.frame_end);
          n_errors++;
        end else begin
          want = want_pixels.pop_front();
          n_checked++;
          if (out_data.out_rgb !== want.out_rgb) begin
            $error("out_rgb mismatch: expected %h, got %h", want.out_rgb, out_data.out_rgb);
            n_errors++;
          end
          if (out_data.frame_end !== want.frame_end) begin
            $error("frame_end mismatch: expected %b, got %b",
                   want.frame_end, out_data.frame_end);
            n_errors++;
          end
        end
      end
    end
  end

  // receiver stall: random short and long holds, plus one requested long hold
  always @(posedge clk) begin
    if (hold_pending) begin
      hold_pending = 1'b0;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!no_gaps && $urandom_range(0, 99) < 25) begin
      stall_left = ($urandom_range(0, 99) < 20) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic rest(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // offer one request and hold it until accepted, then maybe leave a gap
  task automatic send_req(input op_t kind, input pix_t px);
    int r;
    in_valid <= 1'b1;
    in_data  <= '{op: kind, pixel_rgb: px};
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    n_items++;
    if (!no_gaps) begin
      r = $urandom_range(0, 99);
      if (r >= 95) rest($urandom_range(10, 30));
      else if (r >= 70) rest($urandom_range(1, 3));
    end
  endtask

  // wait until every predicted pixel is out and the pipe has drained
  task automatic settle();
    rest(1);
    while (want_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_BITS'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // channels lean toward black and full scale
  function automatic pix_t pick_pixel();
    pix_t p;
    int   r;
    int   k;
    for (k = 0; k < NUM_CH; k++) begin
      r = $urandom_range(0, 99);
      if (r < 12) p[k*CH_BITS +: CH_BITS] = '0;
      else if (r < 24) p[k*CH_BITS +: CH_BITS] = {CH_BITS{1'b1}};
      else p[k*CH_BITS +: CH_BITS] = CH_BITS'($urandom);
    end
    return p;
  endfunction

  // configure, stream one frame, then drain it with w+1 trailing requests
  task automatic run_frame(input mode_t m, input int unsigned wv, input int unsigned hv,
                           input int unsigned thr, input pattern_t pat, input bit noisy,
                           input int pause_at);
    int unsigned weff, heff, i;
    pix_t        px;
    settle();
    write_reg(REG_MODE, m);
    write_reg(REG_WIDTH, wv);
    write_reg(REG_HEIGHT, hv);
    write_reg(REG_THRESH, thr);
    weff = wv & 12'hFFF;
    if (weff == 0) weff = 1;
    if (weff > MAX_WIDTH) weff = MAX_WIDTH;
    heff = hv & 13'h1FFF;
    if (heff == 0) heff = 1;
    for (i = 0; i < weff * heff; i++) begin
      // stray flush while pixels are still due
      if (noisy && (i == 1 || $urandom_range(0, 99) < 6)) send_req(OP_FLUSH, pick_pixel());
      if (pause_at >= 0 && i == pause_at) begin
        rest(1);
        while (want_pixels.size() != 0) @(posedge clk);
      end
      case (pat)
        PAT_CHECKER: px = (((i % weff) + (i / weff)) % 2 != 0) ? {PIX_BITS{1'b1}} : '0;
        PAT_WHITE:   px = {PIX_BITS{1'b1}};
        PAT_BLACK:   px = '0;
        default:     px = pick_pixel();
      endcase
      send_req(OP_PIXEL, px);
    end
    // drain; a pixel after the frame is complete acts as a flush
    for (i = 0; i <= weff; i++) begin
      if (noisy && (i == 0 || $urandom_range(0, 99) < 25)) send_req(OP_PIXEL, pick_pixel());
      else send_req(OP_FLUSH, pick_pixel());
    end
    n_frames++;
  endtask

  task automatic test_directed();
    // zero geometry reads as a single pixel
    run_frame(MODE_SHARPEN, 0, 0, 128, PAT_WHITE, 1'b0, -1);
    run_frame(MODE_EDGE, 3, 2, 0, PAT_CHECKER, 1'b1, -1);
    // sharpen saturates both ways on a checkerboard
    run_frame(MODE_SHARPEN, 2, 2, 255, PAT_CHECKER, 1'b1, -1);
    // edge level lands exactly on the top threshold
    run_frame(MODE_EDGE, 2, 1, 255, PAT_CHECKER, 1'b0, -1);
  endtask

  task automatic test_abort();
    int i;
    settle();
    write_reg(REG_MODE, MODE_EDGE);
    write_reg(REG_THRESH, 40);
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 4096);
    for (i = 0; i < 15; i++) send_req(OP_PIXEL, pick_pixel());
    settle();
    // oversize width aborts the frame and clamps to the line length
    write_reg(REG_WIDTH, 13'h1FFF);
    for (i = 0; i < 6; i++) send_req(OP_PIXEL, pick_pixel());
    settle();
  endtask

  task automatic test_wide_row();
    run_frame(MODE_SHARPEN, WIDE_COLS, 2, 128, PAT_RANDOM, 1'b0, -1);
  endtask

  task automatic test_backpressure();
    settle();
    no_gaps = 1'b1;
    hold_pending = 1'b1;
    run_frame(MODE_EDGE, 8, 6, $urandom_range(0, 255), PAT_RANDOM, 1'b0, -1);
    no_gaps = 1'b0;
  endtask

  task automatic test_pause();
    run_frame(MODE_SHARPEN, 5, 5, 0, PAT_RANDOM, 1'b0, 13);
  endtask

  task automatic test_random();
    int unsigned w, h, thr;
    int          r;
    pattern_t    pat;
    while (n_items < ITEM_BUDGET) begin
      r = $urandom_range(0, 99);
      if (r < 70) w = $urandom_range(1, 6);
      else if (r < 95) w = $urandom_range(7, 24);
      else w = $urandom_range(25, 64);
      h = $urandom_range(1, 5);
      r = $urandom_range(0, 99);
      if (r < 10) thr = 0;
      else if (r < 20) thr = 255;
      else thr = $urandom_range(0, 255);
      r = $urandom_range(0, 99);
      if (r < 85) pat = PAT_RANDOM;
      else if (r < 93) pat = PAT_CHECKER;
      else if (r < 97) pat = PAT_WHITE;
      else pat = PAT_BLACK;
      no_gaps = ($urandom_range(0, 99) < 20);
      run_frame(mode_t'($urandom_range(0, 1)), w, h, thr, pat,
                $urandom_range(0, 99) < 30, -1);
    end
    no_gaps = 1'b0;
  endtask

  initial begin : main
    int t;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_abort();
    test_wide_row();
    test_backpressure();
    test_pause();
    test_random();
    rest(1);
    for (t = 0; t < 20000 && want_pixels.size() != 0; t++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (want_pixels.size() != 0) begin
      $error("%0d predicted pixels never came out", want_pixels.size());
      n_errors++;
    end
    $display("run covered %0d frames, %0d requests, %0d filtered pixels compared",
             n_frames, n_items, n_checked);
    $display("sharpen and edge modes, rows up to %0d wide, width clamping, geometry aborts,",
             WIDE_COLS);
    $display("stray flushes and long output holds");
    if (n_errors == 0) begin
      $display("tb_conv3x3_sharpen_edge_filter_unit: done, clean");
    end else begin
      $display("tb_conv3x3_sharpen_edge_filter_unit: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30000000;
    $display("tb_conv3x3_sharpen_edge_filter_unit: done, errors");
    $finish;
  end

endmodule
